// File: sv/tva_pkg.sv
// shared types, constants and state encodings of the tone allocator
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package tva_pkg;

    // tick counter width and chunk limit
    localparam int TICK_BITS  = 24;
    localparam int MAX_CHUNKS = 32;

    // fixed field widths
    localparam int START_BITS = 24;
    localparam int LEN_BITS   = 13;
    localparam int KEY_BITS   = 7;

    // largest span that still fits in the allowed number of chunks
    localparam int CHUNK_MAX  = 255;
    localparam int MAX_SPAN   = MAX_CHUNKS * CHUNK_MAX;
    localparam int SPAN_BITS  = $clog2(MAX_SPAN + 1);

    localparam logic [7:0] END_MARK  = 8'hFF;
    localparam logic [7:0] PITCH_OFF = 8'h00;

    // input and output packing
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 16;
    localparam int OUT_USER_BITS = 2;

    // register map
    localparam logic REG_TWO_CHANNEL_MODE = 1'b0;

    typedef enum logic [1:0] {
        CMD_NOTE,
        CMD_FINISH,
        CMD_REJECT
    } t_cmd_kind;

    // work handed from the front part to the back part
    typedef struct packed {
        t_cmd_kind              kind;
        logic                   voice;
        logic                   two;
        logic [SPAN_BITS-1:0]   gap;
        logic [SPAN_BITS-1:0]   dur;
        logic [KEY_BITS-1:0]    key;
    } t_cmd;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_EVAL,
        FR_PUSH
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

// File: sv/tva_front.sv
// front part: takes items, tracks channel free ticks, classifies each note
// depends on tva_pkg
`timescale 1ns / 1ps

module tva_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_two_mode,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [tva_pkg::START_BITS-1:0] i_start,
    input  logic [tva_pkg::LEN_BITS-1:0]  i_len,
    input  logic [tva_pkg::KEY_BITS-1:0]  i_key,
    output logic                          o_push,
    output tva_pkg::t_cmd                 o_cmd,
    input  logic                          i_full
);

    localparam int T = tva_pkg::TICK_BITS;

    tva_pkg::t_front_state r_state, n_state;

    logic                           r_func;
    logic [T-1:0]                   r_start;
    logic [tva_pkg::LEN_BITS-1:0]   r_len;
    logic [tva_pkg::KEY_BITS-1:0]   r_key;
    logic [T:0]                     r_end, n_end;
    logic                           r_ch, n_ch;
    logic [T-1:0]                   r_tick, n_tick;
    logic [T-1:0]                   r_free0, n_free0;
    logic [T-1:0]                   r_free1, n_free1;

    logic                           w_accept;
    logic                           w_drop;
    logic [T-1:0]                   w_s2;
    logic [T-1:0]                   w_gap;
    logic [T:0]                     w_dur;
    logic                           w_ovf;

    assign w_accept = i_valid && o_ready;

    // first evaluation step: note end, drop test, channel choice
    always_comb begin
        n_end  = {1'b0, r_start} + (T + 1)'(r_len);
        w_drop = (n_end <= {1'b0, r_free0}) && (!i_two_mode || n_end <= {1'b0, r_free1});
        n_ch   = i_two_mode && !(r_free0 < r_free1);
        n_tick = n_ch ? r_free1 : r_free0;
    end

    // second evaluation step: head trim, gap, remaining length, chunk limit
    always_comb begin
        w_s2  = (r_start < r_tick) ? r_tick : r_start;
        w_gap = w_s2 - r_tick;
        w_dur = r_end - {1'b0, w_s2};
        w_ovf = (w_gap > T'(tva_pkg::MAX_SPAN)) || (w_dur > (T + 1)'(tva_pkg::MAX_SPAN));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tva_pkg::FR_IDLE: begin
                if (w_accept) n_state = tva_pkg::FR_EVAL;
            end
            tva_pkg::FR_EVAL: begin
                if (!r_func && w_drop) n_state = tva_pkg::FR_IDLE;
                else n_state = tva_pkg::FR_PUSH;
            end
            tva_pkg::FR_PUSH: begin
                if (!i_full) n_state = tva_pkg::FR_IDLE;
            end
            default: n_state = tva_pkg::FR_IDLE;
        endcase
    end

    // outputs: command build and free tick update
    always_comb begin
        o_ready   = (r_state == tva_pkg::FR_IDLE);
        o_push    = (r_state == tva_pkg::FR_PUSH) && !i_full;
        o_cmd.voice = r_ch;
        o_cmd.two   = i_two_mode;
        o_cmd.gap   = w_gap[tva_pkg::SPAN_BITS-1:0];
        o_cmd.dur   = w_dur[tva_pkg::SPAN_BITS-1:0];
        o_cmd.key   = (r_key == '0) ? tva_pkg::KEY_BITS'(1) : r_key;
        if (r_func) o_cmd.kind = tva_pkg::CMD_FINISH;
        else if (w_ovf) o_cmd.kind = tva_pkg::CMD_REJECT;
        else o_cmd.kind = tva_pkg::CMD_NOTE;

        n_free0 = r_free0;
        n_free1 = r_free1;
        if (o_push) begin
            if (r_func) begin
                n_free0 = '0;
                n_free1 = '0;
            end else if (!w_ovf) begin
                // saturate an end beyond the tick range
                if (r_ch) n_free1 = r_end[T] ? '1 : r_end[T-1:0];
                else n_free0 = r_end[T] ? '1 : r_end[T-1:0];
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tva_pkg::FR_IDLE;
            r_free0 <= '0;
            r_free1 <= '0;
        end else begin
            r_state <= n_state;
            r_free0 <= n_free0;
            r_free1 <= n_free1;
        end
    end

    // item and evaluation registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_start <= T'(i_start);
            r_len   <= i_len;
            r_key   <= i_key;
        end
        if (r_state == tva_pkg::FR_EVAL) begin
            r_end  <= n_end;
            r_ch   <= n_ch;
            r_tick <= n_tick;
        end
    end

endmodule

// File: sv/tva_queue.sv
// two-entry command queue between the front and back parts
// depends on tva_pkg for the command type
`timescale 1ns / 1ps

module tva_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tva_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output tva_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    tva_pkg::t_cmd r_mem [2];
    logic          r_wr, n_wr;
    logic          r_rd, n_rd;
    logic [1:0]    r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr ^ i_push;
        n_rd    = r_rd ^ i_pop;
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        else if (!i_push && i_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// File: sv/tva_back.sv
// back part: splits each command into silence, note, end marker and overflow chunks
// depends on tva_pkg; drives the registered output item
`timescale 1ns / 1ps

module tva_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tva_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_voice,
    output logic [7:0]    o_pitch,
    output logic [7:0]    o_ticks,
    output logic          o_ovf,
    output logic          o_last
);

    localparam int S = tva_pkg::SPAN_BITS;

    tva_pkg::t_back_state r_state, n_state;
    tva_pkg::t_cmd        r_cmd, n_cmd;
    logic                 r_fin, n_fin;

    logic                 r_valid;
    logic                 r_voice, n_voice;
    logic [7:0]           r_pitch, n_pitch;
    logic [7:0]           r_ticks, n_ticks;
    logic                 r_ovf, n_ovf;
    logic                 r_last, n_last;

    logic                 w_slot;
    logic                 w_emit;
    logic                 w_done;
    logic                 w_gap_big;
    logic                 w_dur_big;
    logic [7:0]           w_gap_c;
    logic [7:0]           w_dur_c;

    assign w_slot    = !r_valid || i_ready;
    assign w_gap_big = r_cmd.gap > S'(tva_pkg::CHUNK_MAX);
    assign w_dur_big = r_cmd.dur > S'(tva_pkg::CHUNK_MAX);
    assign w_gap_c   = w_gap_big ? 8'hFF : r_cmd.gap[7:0];
    assign w_dur_c   = w_dur_big ? 8'hFF : r_cmd.dur[7:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tva_pkg::BK_IDLE: begin
                if (!i_empty) n_state = tva_pkg::BK_RUN;
            end
            tva_pkg::BK_RUN: begin
                if (w_done) n_state = tva_pkg::BK_IDLE;
            end
            default: n_state = tva_pkg::BK_IDLE;
        endcase
    end

    // chunk generation
    always_comb begin
        o_pop   = (r_state == tva_pkg::BK_IDLE) && !i_empty;
        n_cmd   = r_cmd;
        n_fin   = r_fin;
        w_emit  = 1'b0;
        w_done  = 1'b0;
        n_voice = r_cmd.voice;
        n_pitch = tva_pkg::PITCH_OFF;
        n_ticks = 8'd0;
        n_ovf   = 1'b0;
        n_last  = 1'b0;
        if (o_pop) begin
            n_cmd = i_cmd;
            n_fin = 1'b0;
        end else if (r_state == tva_pkg::BK_RUN && w_slot) begin
            w_emit = 1'b1;
            case (r_cmd.kind)
                tva_pkg::CMD_REJECT: begin
                    n_ovf  = 1'b1;
                    n_last = 1'b1;
                    w_done = 1'b1;
                end
                tva_pkg::CMD_FINISH: begin
                    n_pitch = tva_pkg::END_MARK;
                    n_voice = r_fin;
                    n_last  = r_fin || !r_cmd.two;
                    w_done  = n_last;
                    n_fin   = 1'b1;
                end
                tva_pkg::CMD_NOTE: begin
                    if (r_cmd.gap != '0) begin
                        // silence up to the note start
                        n_ticks   = w_gap_c;
                        n_cmd.gap = r_cmd.gap - S'(w_gap_c);
                        n_last    = !w_gap_big && (r_cmd.dur == '0);
                    end else begin
                        n_pitch   = 8'(r_cmd.key);
                        n_ticks   = w_dur_c;
                        n_cmd.dur = r_cmd.dur - S'(w_dur_c);
                        n_last    = !w_dur_big;
                    end
                    w_done = n_last;
                end
                default: begin
                    w_emit = 1'b0;
                    w_done = 1'b1;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tva_pkg::BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    // command and output payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_fin <= n_fin;
        if (w_emit) begin
            r_voice <= n_voice;
            r_pitch <= n_pitch;
            r_ticks <= n_ticks;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_voice = r_voice;
    assign o_pitch = r_pitch;
    assign o_ticks = r_ticks;
    assign o_ovf   = r_ovf;
    assign o_last  = r_last;

endmodule

// File: sv/two_voice_tone_allocator_core.sv
// top level of the two channel tone allocator: config register, front, queue, back
// depends on tva_pkg, tva_front, tva_queue and tva_back
`timescale 1ns / 1ps
//
//  channel  direction  handshake                   payload
//  s_axis   in         s_axis_tvalid/tready        tdata start,length,note; tuser func
//  m_axis   out        m_axis_tvalid/tready        tdata pitch,ticks; tuser voice,overflow
//  apb      in         psel/penable/pwrite/pready  two_channel_mode at address 0
//
//  an item passes the front states take, evaluate and hand over, is loaded by
//  the back, which emits one item per cycle while the output is ready; a note
//  holds the back to its last chunk: the chunk emitter sets the sustained rate.
//  reset is synchronous, active low; it clears both free ticks and sets
//  two channel mode. a stalled output holds the back, the two-entry queue
//  then fills and the front stops taking items.

module two_voice_tone_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // note start [23:0], length_ticks [36:24], note_number [43:37], zero fill
    input  logic [tva_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // func [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pitch_code [7:0], chunk_ticks [15:8]
    output logic [tva_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // voice [0], overflow [1]
    output logic [tva_pkg::OUT_USER_BITS-1:0] m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic          r_two_mode;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    tva_pkg::t_cmd w_cmd_in;
    tva_pkg::t_cmd w_cmd_out;
    logic [7:0]    w_pitch;
    logic [7:0]    w_ticks;
    logic          w_voice;
    logic          w_ovf;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_mode <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == tva_pkg::REG_TWO_CHANNEL_MODE) begin
            r_two_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == tva_pkg::REG_TWO_CHANNEL_MODE) prdata = {31'd0, r_two_mode};
    end

    tva_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_two_mode (r_two_mode),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_start    (s_axis_tdata[23:0]),
        .i_len      (s_axis_tdata[36:24]),
        .i_key      (s_axis_tdata[43:37]),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in),
        .i_full     (w_full)
    );

    tva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    tva_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_cmd_out),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_voice (w_voice),
        .o_pitch (w_pitch),
        .o_ticks (w_ticks),
        .o_ovf   (w_ovf),
        .o_last  (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = {w_ticks, w_pitch};
    assign m_axis_tuser = {w_ovf, w_voice};

endmodule
